### src/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants for the I2C register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int LEN_BITS  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ADDR_NACK = 2'd1;
  localparam logic [1:0] STAT_DATA_NACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_HALF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO   = 2'd2;

  localparam logic [CFG_W-1:0] BIT_HALF_RST  = 16'd2;
  localparam logic [CFG_W-1:0] EDGE_HOLD_RST = 16'd4;
  localparam logic [CFG_W-1:0] ACK_TMO_RST   = 16'd250;

  typedef struct packed {
    logic [CFG_W-1:0] bit_half_ticks;
    logic [CFG_W-1:0] edge_hold_ticks;
    logic [CFG_W-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_read;
    logic [7:0]  device_addr;
    logic [7:0]  reg_index;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic        sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       need_data;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

### src/i2crm_in_if.sv
// ----------------------------------------------------------------------------
// i2crm_in_if
// Input channel: ticks, transaction requests and write bytes.
// ----------------------------------------------------------------------------
interface i2crm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        is_read;
  logic [7:0]  device_addr;
  logic [7:0]  reg_index;
  logic [15:0] byte_count;
  logic [7:0]  data_byte;
  logic        sda_sample;

  modport source (
    output valid, kind, is_read, device_addr, reg_index, byte_count, data_byte, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, kind, is_read, device_addr, reg_index, byte_count, data_byte, sda_sample,
    output ready
  );
endinterface

### src/i2crm_out_if.sv
// ----------------------------------------------------------------------------
// i2crm_out_if
// Output channel: pin levels and transaction status, one word per input word.
// ----------------------------------------------------------------------------
interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic       rx_last;
  logic       need_data;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (
    output valid, scl_level, sda_level, sda_drive, rx_byte, rx_valid, rx_last,
           need_data, busy_res, done_res, status,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_drive, rx_byte, rx_valid, rx_last,
           need_data, busy_res, done_res, status,
    output ready
  );
endinterface

### src/i2c_register_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// Tick-driven I2C master for register reads and writes.
// ----------------------------------------------------------------------------
// Every input word (a timing tick with the SDA sample, a transaction request
// or a write byte) yields exactly one output word with the pin levels and
// status after it. Throughput is one word per clock unless output stalls:
// the sequencer updates its state in the cycle a word is accepted and the
// result lands in an output register. Input is ready when that register is
// empty or being read in the same cycle. Users must write timing registers
// via the cfg port while no transaction is active; the block does not check.
module i2c_register_master_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [i2crm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2crm_pkg::CFG_W-1:0]        cfg_data,
  i2crm_in_if.sink                           in_ch,
  i2crm_out_if.source                        out_ch
);
  import i2crm_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  out_valid;
  logic  accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign item.kind        = in_ch.kind;
  assign item.is_read     = in_ch.is_read;
  assign item.device_addr = in_ch.device_addr;
  assign item.reg_index   = in_ch.reg_index;
  assign item.byte_count  = in_ch.byte_count;
  assign item.data_byte   = in_ch.data_byte;
  assign item.sda_sample  = in_ch.sda_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_half_ticks  <= BIT_HALF_RST;
      cfg.edge_hold_ticks <= EDGE_HOLD_RST;
      cfg.ack_timeout     <= ACK_TMO_RST;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIT_HALF:  cfg.bit_half_ticks  <= cfg_data;
          CFG_EDGE_HOLD: cfg.edge_hold_ticks <= cfg_data;
          CFG_ACK_TMO:   cfg.ack_timeout     <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  i2crm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  assign out_ch.valid     = out_valid;
  assign out_ch.scl_level = res.scl_level;
  assign out_ch.sda_level = res.sda_level;
  assign out_ch.sda_drive = res.sda_drive;
  assign out_ch.rx_byte   = res.rx_byte;
  assign out_ch.rx_valid  = res.rx_valid;
  assign out_ch.rx_last   = res.rx_last;
  assign out_ch.need_data = res.need_data;
  assign out_ch.busy_res  = res.busy_res;
  assign out_ch.done_res  = res.done_res;
  assign out_ch.status    = res.status;

`ifndef ASSERT_OFF
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");
`endif

endmodule

### src/i2crm_core.sv
// ----------------------------------------------------------------------------
// i2crm_core
// Bus sequencer: one word per step, state and result word registered.
// ----------------------------------------------------------------------------
module i2crm_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  i2crm_pkg::item_t item,
  input  i2crm_pkg::cfg_t  cfg,
  output i2crm_pkg::res_t  res
);
  import i2crm_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_RS_SETUP, P_ST_HIGH, P_ST_LOW, P_ST_END, P_TX_SETUP, P_TX_HIGH,
    P_TX_LOW, P_ACK_REL, P_ACK_HIGH, P_ACK_POLL, P_ACK_END, P_NEED, P_RX_LOW,
    P_RX_HIGH, P_MA_SETUP, P_MA_DATA, P_MA_HIGH, P_MA_END, P_SP_PRE, P_SP_LOW,
    P_SP_CLK, P_SP_HIGH
  } phase_t;

  typedef enum logic [1:0] {S_ADDR, S_INDEX, S_DATA, S_RADDR} stage_t;

  phase_t              phase, phase_next;
  stage_t              stage, stage_next;
  logic [15:0]         tick_count, tick_count_next;
  logic [15:0]         ack_wait_count, ack_wait_count_next;
  logic [2:0]          bit_index, bit_index_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]          saved_addr, saved_addr_next;
  logic [7:0]          saved_index, saved_index_next;
  logic                read_mode, read_mode_next;
  logic [1:0]          status, status_next;
  logic                scl, scl_next;
  logic                sda_out, sda_out_next;
  logic                sda_drive, sda_drive_next;

  logic                rx_valid_next, rx_last_next, done_next, do_poll;
  logic [7:0]          rx_byte_next;
  logic [15:0]         tick_inc, poll_base;
  logic [LEN_BITS-1:0] bytes_dec;
  logic                half_done, edge_done;

  assign tick_inc  = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign half_done = tick_inc >= cfg.bit_half_ticks;
  assign edge_done = tick_inc >= cfg.edge_hold_ticks;
  assign poll_base = (phase == P_ACK_HIGH) ? 16'd0 : ack_wait_count;
  assign bytes_dec = (bytes_left != '0) ? bytes_left - 1'b1 : '0;

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    tick_count_next     = tick_count;
    ack_wait_count_next = ack_wait_count;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    saved_addr_next     = saved_addr;
    saved_index_next    = saved_index;
    read_mode_next      = read_mode;
    status_next         = status;
    scl_next            = scl;
    sda_out_next        = sda_out;
    sda_drive_next      = sda_drive;
    rx_valid_next       = 1'b0;
    rx_last_next        = 1'b0;
    rx_byte_next        = 8'h00;
    done_next           = 1'b0;
    do_poll             = 1'b0;

    case (item.kind)
      KIND_START: begin
        if (phase == P_IDLE) begin
          read_mode_next   = item.is_read;
          saved_addr_next  = item.device_addr;
          saved_index_next = item.reg_index;
          bytes_left_next  = item.byte_count[LEN_BITS-1:0];
          shift_byte_next  = item.device_addr;
          stage_next       = S_ADDR;
          status_next      = STAT_OK;
          scl_next         = 1'b1;
          sda_drive_next   = 1'b1;
          sda_out_next     = 1'b1;
          phase_next       = P_ST_HIGH;
          tick_count_next  = '0;
        end
      end
      KIND_DATA: begin
        if (phase == P_NEED) begin
          shift_byte_next = item.data_byte;
          bit_index_next  = '0;
          sda_drive_next  = 1'b1;
          sda_out_next    = item.data_byte[7];
          phase_next      = P_TX_SETUP;
          tick_count_next = '0;
        end
      end
      KIND_TICK: begin
        case (phase)
          P_RS_SETUP, P_TX_SETUP, P_ACK_REL, P_MA_DATA: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              scl_next        = 1'b1;
              tick_count_next = '0;
              case (phase)
                P_RS_SETUP: phase_next = P_ST_HIGH;
                P_TX_SETUP: phase_next = P_TX_HIGH;
                P_ACK_REL:  phase_next = P_ACK_HIGH;
                default:    phase_next = P_MA_HIGH;
              endcase
            end
          end
          P_ST_HIGH: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              sda_drive_next  = 1'b1;
              sda_out_next    = 1'b0;
              phase_next      = P_ST_LOW;
              tick_count_next = '0;
            end
          end
          P_ST_LOW: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              scl_next        = 1'b0;
              phase_next      = P_ST_END;
              tick_count_next = '0;
            end
          end
          P_ST_END: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              bit_index_next  = '0;
              sda_drive_next  = 1'b1;
              sda_out_next    = shift_byte[7];
              phase_next      = P_TX_SETUP;
              tick_count_next = '0;
            end
          end
          P_TX_HIGH: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              scl_next        = 1'b0;
              phase_next      = P_TX_LOW;
              tick_count_next = '0;
            end
          end
          P_TX_LOW: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              tick_count_next = '0;
              if (bit_index == 3'd7) begin
                sda_drive_next = 1'b0;
                sda_out_next   = 1'b1;
                phase_next     = P_ACK_REL;
              end else begin
                bit_index_next  = bit_index + 3'd1;
                shift_byte_next = {shift_byte[6:0], 1'b0};
                sda_drive_next  = 1'b1;
                sda_out_next    = shift_byte[6];
                phase_next      = P_TX_SETUP;
              end
            end
          end
          P_ACK_HIGH: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              phase_next          = P_ACK_POLL;
              tick_count_next     = '0;
              ack_wait_count_next = '0;
              do_poll             = 1'b1;
            end
          end
          P_ACK_POLL: do_poll = 1'b1;
          P_ACK_END: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              tick_count_next = '0;
              case (stage)
                S_ADDR: begin
                  stage_next      = S_INDEX;
                  shift_byte_next = saved_index;
                  bit_index_next  = '0;
                  sda_drive_next  = 1'b1;
                  sda_out_next    = saved_index[7];
                  phase_next      = P_TX_SETUP;
                end
                S_INDEX: begin
                  if (read_mode) begin
                    stage_next      = S_RADDR;
                    shift_byte_next = saved_addr | 8'h01;
                    sda_drive_next  = 1'b1;
                    sda_out_next    = 1'b1;
                    phase_next      = P_RS_SETUP;
                  end else begin
                    stage_next = S_DATA;
                    if (bytes_left == '0) begin
                      sda_drive_next = 1'b1;
                      sda_out_next   = 1'b0;
                      phase_next     = P_SP_LOW;
                    end else begin
                      phase_next = P_NEED;
                    end
                  end
                end
                S_DATA: begin
                  bytes_left_next = bytes_dec;
                  if (bytes_dec == '0) begin
                    sda_drive_next = 1'b1;
                    sda_out_next   = 1'b0;
                    phase_next     = P_SP_LOW;
                  end else begin
                    phase_next = P_NEED;
                  end
                end
                default: begin
                  if (bytes_left == '0) begin
                    sda_drive_next = 1'b1;
                    sda_out_next   = 1'b0;
                    phase_next     = P_SP_LOW;
                  end else begin
                    bit_index_next = '0;
                    phase_next     = P_RX_LOW;
                  end
                end
              endcase
            end
          end
          P_RX_LOW: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              scl_next        = 1'b1;
              phase_next      = P_RX_HIGH;
              tick_count_next = '0;
            end
          end
          P_RX_HIGH: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              shift_byte_next = {shift_byte[6:0], item.sda_sample};
              scl_next        = 1'b0;
              tick_count_next = '0;
              if (bit_index == 3'd7) begin
                rx_valid_next = 1'b1;
                rx_byte_next  = {shift_byte[6:0], item.sda_sample};
                rx_last_next  = (bytes_left == LEN_BITS'(1));
                phase_next    = P_MA_SETUP;
              end else begin
                bit_index_next = bit_index + 3'd1;
                phase_next     = P_RX_LOW;
              end
            end
          end
          P_MA_SETUP: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              sda_drive_next  = 1'b1;
              sda_out_next    = (bytes_left == LEN_BITS'(1));
              phase_next      = P_MA_DATA;
              tick_count_next = '0;
            end
          end
          P_MA_HIGH: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              scl_next        = 1'b0;
              bytes_left_next = bytes_dec;
              phase_next      = P_MA_END;
              tick_count_next = '0;
            end
          end
          P_MA_END: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              tick_count_next = '0;
              if (bytes_left == '0) begin
                sda_drive_next = 1'b1;
                sda_out_next   = 1'b0;
                phase_next     = P_SP_LOW;
              end else begin
                sda_drive_next = 1'b0;
                sda_out_next   = 1'b1;
                bit_index_next = '0;
                phase_next     = P_RX_LOW;
              end
            end
          end
          P_SP_PRE: begin
            tick_count_next = tick_inc;
            if (half_done) begin
              sda_drive_next  = 1'b1;
              sda_out_next    = 1'b0;
              phase_next      = P_SP_LOW;
              tick_count_next = '0;
            end
          end
          P_SP_LOW: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              scl_next        = 1'b1;
              phase_next      = P_SP_CLK;
              tick_count_next = '0;
            end
          end
          P_SP_CLK: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              sda_drive_next  = 1'b1;
              sda_out_next    = 1'b1;
              phase_next      = P_SP_HIGH;
              tick_count_next = '0;
            end
          end
          P_SP_HIGH: begin
            tick_count_next = tick_inc;
            if (edge_done) begin
              done_next       = 1'b1;
              phase_next      = P_IDLE;
              tick_count_next = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // acknowledge wait: low is ACK, high past the timeout aborts
    if (do_poll) begin
      if (!item.sda_sample) begin
        scl_next        = 1'b0;
        phase_next      = P_ACK_END;
        tick_count_next = '0;
      end else if (poll_base >= cfg.ack_timeout) begin
        scl_next        = 1'b0;
        status_next     = (stage == S_ADDR || stage == S_RADDR) ? STAT_ADDR_NACK
                                                                : STAT_DATA_NACK;
        phase_next      = P_SP_PRE;
        tick_count_next = '0;
      end else begin
        ack_wait_count_next = poll_base + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= P_IDLE;
      stage          <= S_ADDR;
      tick_count     <= '0;
      ack_wait_count <= '0;
      bit_index      <= '0;
      shift_byte     <= '0;
      bytes_left     <= '0;
      saved_addr     <= '0;
      saved_index    <= '0;
      read_mode      <= 1'b0;
      status         <= STAT_OK;
      scl            <= 1'b1;
      sda_out        <= 1'b1;
      sda_drive      <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      stage          <= stage_next;
      tick_count     <= tick_count_next;
      ack_wait_count <= ack_wait_count_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      saved_addr     <= saved_addr_next;
      saved_index    <= saved_index_next;
      read_mode      <= read_mode_next;
      status         <= status_next;
      scl            <= scl_next;
      sda_out        <= sda_out_next;
      sda_drive      <= sda_drive_next;
      res.scl_level  <= scl_next;
      res.sda_level  <= sda_out_next | ~sda_drive_next;
      res.sda_drive  <= sda_drive_next;
      res.rx_byte    <= rx_byte_next;
      res.rx_valid   <= rx_valid_next;
      res.rx_last    <= rx_last_next;
      res.need_data  <= (phase_next == P_NEED);
      res.busy_res   <= (phase_next != P_IDLE);
      res.done_res   <= done_next;
      res.status     <= status_next;
    end
  end

`ifndef ASSERT_OFF
  a_rx_pins: assert property (@(posedge clk) disable iff (rst)
    step |=> !(res.rx_valid && (res.scl_level || res.sda_drive)))
    else $error("byte received while SCL high or SDA driven");
  a_done_pins: assert property (@(posedge clk) disable iff (rst)
    step |=> !(res.done_res && (res.busy_res || !res.scl_level || !res.sda_level)))
    else $error("transaction ended without idle bus");
  a_need_scl: assert property (@(posedge clk) disable iff (rst)
    step |=> !(res.need_data && (res.scl_level || !res.busy_res)))
    else $error("write byte requested with SCL high or no transaction");
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (step && phase == P_IDLE && item.kind == KIND_TICK) |=> !res.busy_res)
    else $error("tick left idle state");
`endif

endmodule

### bench/i2crm_checker.sv
// ----------------------------------------------------------------------------
// i2crm_checker
// Predicts and checks every output word of the I2C register master.
// ----------------------------------------------------------------------------
// Watches both channels and the cfg port. Each accepted input word steps a
// cycle-free model of the pin sequencer, and the word it yields is queued.
// Each accepted output word is compared field by field with the oldest
// queued word. The failure count and the number of words still owed go to
// the bench top.
module i2crm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [i2crm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2crm_pkg::CFG_W-1:0]     cfg_data,
  i2crm_in_if                             in_ch,
  i2crm_out_if                            out_ch,
  output int                              fail_count,
  output int                              pending,
  output int                              words_checked,
  output int                              rx_bytes,
  output int                              aborts
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2crm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_RS_SETUP, PH_ST_HIGH, PH_ST_LOW, PH_ST_END, PH_TX_SETUP,
    PH_TX_HIGH, PH_TX_LOW, PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_ACK_END,
    PH_NEED, PH_RX_LOW, PH_RX_HIGH, PH_MA_SETUP, PH_MA_DATA, PH_MA_HIGH,
    PH_MA_END, PH_SP_PRE, PH_SP_LOW, PH_SP_CLK, PH_SP_HIGH
  } seq_phase_e;

  typedef enum logic [1:0] {ST_ADDR, ST_INDEX, ST_DATA, ST_RADDR} byte_stage_e;

  cfg_t        timing;
  seq_phase_e  ph;
  byte_stage_e stage_q;
  logic [15:0] hold_cnt, ack_wait, remaining;
  logic [2:0]  bit_no;
  logic [7:0]  shreg, addr_q, index_q;
  logic        rd_q, scl_q, sda_q, drv_q;
  logic [1:0]  stat_q;

  res_t  owed_q[$];
  item_t word_in;
  res_t  got, want;

  function automatic void enter(seq_phase_e p);
    ph = p;
    hold_cnt = '0;
  endfunction

  function automatic bit held(logic [15:0] n);
    if (hold_cnt != 16'hFFFF) hold_cnt++;
    return hold_cnt >= n;
  endfunction

  function automatic void drive_sda(logic v);
    drv_q = 1'b1;
    sda_q = v;
  endfunction

  function automatic void release_sda();
    drv_q = 1'b0;
    sda_q = 1'b1;
  endfunction

  function automatic void load_tx();
    bit_no = '0;
    drive_sda(shreg[7]);
    enter(PH_TX_SETUP);
  endfunction

  function automatic void begin_stop();
    drive_sda(1'b0);
    enter(PH_SP_LOW);
  endfunction

  function automatic void poll_ack(logic s);
    if (!s) begin
      scl_q = 1'b0;
      enter(PH_ACK_END);
    end else if (ack_wait >= timing.ack_timeout) begin
      scl_q = 1'b0;
      stat_q = (stage_q == ST_ADDR || stage_q == ST_RADDR) ? STAT_ADDR_NACK : STAT_DATA_NACK;
      enter(PH_SP_PRE);
    end else begin
      ack_wait++;
    end
  endfunction

  function automatic res_t sequence_step(item_t w);
    res_t        r;
    logic [15:0] bh, eh;
    r  = '0;
    bh = timing.bit_half_ticks;
    eh = timing.edge_hold_ticks;
    case (w.kind)
      KIND_START: if (ph == PH_IDLE) begin
        rd_q      = w.is_read;
        addr_q    = w.device_addr;
        index_q   = w.reg_index;
        remaining = w.byte_count;
        shreg     = w.device_addr;
        stage_q   = ST_ADDR;
        stat_q    = STAT_OK;
        scl_q     = 1'b1;
        drive_sda(1'b1);
        enter(PH_ST_HIGH);
      end
      KIND_DATA: if (ph == PH_NEED) begin
        shreg = w.data_byte;
        load_tx();
      end
      KIND_TICK: case (ph)
        PH_RS_SETUP: if (held(bh)) begin scl_q = 1'b1; enter(PH_ST_HIGH); end
        PH_ST_HIGH:  if (held(eh)) begin drive_sda(1'b0); enter(PH_ST_LOW); end
        PH_ST_LOW:   if (held(eh)) begin scl_q = 1'b0; enter(PH_ST_END); end
        PH_ST_END:   if (held(bh)) load_tx();
        PH_TX_SETUP: if (held(bh)) begin scl_q = 1'b1; enter(PH_TX_HIGH); end
        PH_TX_HIGH:  if (held(bh)) begin scl_q = 1'b0; enter(PH_TX_LOW); end
        PH_TX_LOW: if (held(bh)) begin
          if (bit_no == 3'd7) begin
            release_sda();
            enter(PH_ACK_REL);
          end else begin
            bit_no++;
            shreg = shreg << 1;
            drive_sda(shreg[7]);
            enter(PH_TX_SETUP);
          end
        end
        PH_ACK_REL: if (held(bh)) begin scl_q = 1'b1; enter(PH_ACK_HIGH); end
        PH_ACK_HIGH: if (held(bh)) begin
          enter(PH_ACK_POLL);
          ack_wait = '0;
          poll_ack(w.sda_sample);
        end
        PH_ACK_POLL: poll_ack(w.sda_sample);
        PH_ACK_END: if (held(bh)) begin
          case (stage_q)
            ST_ADDR: begin
              stage_q = ST_INDEX;
              shreg = index_q;
              load_tx();
            end
            ST_INDEX: begin
              if (rd_q) begin
                stage_q = ST_RADDR;
                shreg = addr_q | 8'h01;
                drive_sda(1'b1);
                enter(PH_RS_SETUP);
              end else begin
                stage_q = ST_DATA;
                if (remaining == '0) begin_stop();
                else enter(PH_NEED);
              end
            end
            ST_DATA: begin
              if (remaining != '0) remaining--;
              if (remaining == '0) begin_stop();
              else enter(PH_NEED);
            end
            default: begin
              if (remaining == '0) begin
                begin_stop();
              end else begin
                bit_no = '0;
                enter(PH_RX_LOW);
              end
            end
          endcase
        end
        PH_RX_LOW: if (held(eh)) begin scl_q = 1'b1; enter(PH_RX_HIGH); end
        PH_RX_HIGH: if (held(eh)) begin
          shreg = {shreg[6:0], w.sda_sample};
          scl_q = 1'b0;
          if (bit_no == 3'd7) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = shreg;
            r.rx_last  = (remaining == 16'd1);
            enter(PH_MA_SETUP);
          end else begin
            bit_no++;
            enter(PH_RX_LOW);
          end
        end
        PH_MA_SETUP: if (held(bh)) begin drive_sda(remaining == 16'd1); enter(PH_MA_DATA); end
        PH_MA_DATA: if (held(bh)) begin scl_q = 1'b1; enter(PH_MA_HIGH); end
        PH_MA_HIGH: if (held(bh)) begin
          scl_q = 1'b0;
          if (remaining != '0) remaining--;
          enter(PH_MA_END);
        end
        PH_MA_END: if (held(bh)) begin
          if (remaining == '0) begin
            begin_stop();
          end else begin
            release_sda();
            bit_no = '0;
            enter(PH_RX_LOW);
          end
        end
        PH_SP_PRE:  if (held(bh)) begin_stop();
        PH_SP_LOW:  if (held(eh)) begin scl_q = 1'b1; enter(PH_SP_CLK); end
        PH_SP_CLK:  if (held(eh)) begin drive_sda(1'b1); enter(PH_SP_HIGH); end
        PH_SP_HIGH: if (held(eh)) begin r.done_res = 1'b1; enter(PH_IDLE); end
        default: ;
      endcase
      default: ;
    endcase
    r.scl_level = scl_q;
    r.sda_level = drv_q ? sda_q : 1'b1;
    r.sda_drive = drv_q;
    r.need_data = (ph == PH_NEED);
    r.busy_res  = (ph != PH_IDLE);
    r.status    = stat_q;
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("scl=%b sda=%b drv=%b rx=%h v=%b last=%b need=%b busy=%b done=%b st=%0d",
                     r.scl_level, r.sda_level, r.sda_drive, r.rx_byte, r.rx_valid,
                     r.rx_last, r.need_data, r.busy_res, r.done_res, r.status);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      timing    = '{bit_half_ticks: BIT_HALF_RST, edge_hold_ticks: EDGE_HOLD_RST,
                    ack_timeout: ACK_TMO_RST};
      ph        = PH_IDLE;
      stage_q   = ST_ADDR;
      hold_cnt  = '0;
      ack_wait  = '0;
      remaining = '0;
      bit_no    = '0;
      shreg     = '0;
      addr_q    = '0;
      index_q   = '0;
      rd_q      = 1'b0;
      stat_q    = STAT_OK;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      drv_q     = 1'b1;
      owed_q.delete();
      fail_count    <= 0;
      pending       <= 0;
      words_checked <= 0;
      rx_bytes      <= 0;
      aborts        <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIT_HALF:  timing.bit_half_ticks  = cfg_data;
          CFG_EDGE_HOLD: timing.edge_hold_ticks = cfg_data;
          CFG_ACK_TMO:   timing.ack_timeout     = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.scl_level, out_ch.sda_level, out_ch.sda_drive, out_ch.rx_byte,
               out_ch.rx_valid, out_ch.rx_last, out_ch.need_data, out_ch.busy_res,
               out_ch.done_res, out_ch.status};
        words_checked <= words_checked + 1;
        if (got.rx_valid) rx_bytes <= rx_bytes + 1;
        if (got.done_res && got.status != STAT_OK) aborts <= aborts + 1;
        if (owed_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word: %s", show(got));
          fail_count <= fail_count + 1;
        end else begin
          want = owed_q.pop_front();
          if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
              got.sda_drive !== want.sda_drive || got.rx_byte !== want.rx_byte ||
              got.rx_valid !== want.rx_valid || got.rx_last !== want.rx_last ||
              got.need_data !== want.need_data || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.status !== want.status) begin
            if (fail_count < 10) begin
              $display("mismatch at word %0d: expected %s", words_checked, show(want));
              $display("                      actual   %s", show(got));
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        word_in = {in_ch.kind, in_ch.is_read, in_ch.device_addr, in_ch.reg_index,
                   in_ch.byte_count, in_ch.data_byte, in_ch.sda_sample};
        owed_q.push_back(sequence_step(word_in));
      end
      pending <= owed_q.size();
    end
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the I2C register master.
// ----------------------------------------------------------------------------
// Runs register writes and reads against a crude slave that pulls SDA low
// with a per-transaction probability, so acknowledges pass or time out and
// read bits vary. Write bytes are offered when a word with need_data comes
// back. Directed cases first, then random transactions with stray words
// mixed in, under three idling regimes; the timing registers are changed
// between transactions, including their zero and full-scale values.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2crm_pkg::*;

  localparam logic [1:0]           KIND_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [15:0] TMO_CHOICES [4] = '{16'd0, 16'd1, 16'd3, 16'd250};
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 240;
  localparam int END_WAIT       = 8;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 sink_ready = 1'b0;

  int tx_idle_pct = 14;
  int rx_idle_pct = 52;
  int words_sent = 0;
  int need_seen = 0;
  int done_seen = 0;
  int stall_cycles = 0;
  int txn_total = 0;
  int txn_reads = 0;
  int fail_count, pending, words_checked, rx_bytes, aborts;

  i2crm_in_if  in_ch ();
  i2crm_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  i2c_register_master_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  i2crm_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .rx_bytes      (rx_bytes),
    .aborts        (aborts)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    sink_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (out_ch.need_data) need_seen <= need_seen + 1;
      if (out_ch.done_res) done_seen <= done_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic item_t rand_word(logic [1:0] k);
    item_t w;
    w.kind        = k;
    w.is_read     = 1'($urandom);
    w.device_addr = 8'($urandom);
    w.reg_index   = 8'($urandom);
    w.byte_count  = 16'($urandom);
    w.data_byte   = 8'($urandom);
    w.sda_sample  = 1'($urandom);
    return w;
  endfunction

  // slave holds SDA low with probability p_low
  function automatic item_t tick_word(int p_low);
    item_t w;
    w = rand_word(KIND_TICK);
    w.sda_sample = ($urandom_range(99) >= p_low);
    return w;
  endfunction

  function automatic item_t noise_word(bit with_start);
    item_t w;
    case ($urandom_range(with_start ? 2 : 1))
      0:       w = rand_word(KIND_NONE);
      1:       w = rand_word(KIND_DATA);
      default: w = rand_word(KIND_START);
    endcase
    w.byte_count = 16'($urandom_range(3));
    return w;
  endfunction

  task automatic push_word(input item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.kind, in_ch.is_read, in_ch.device_addr, in_ch.reg_index,
     in_ch.byte_count, in_ch.data_byte, in_ch.sda_sample} <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic set_timing(input logic [15:0] half, input logic [15:0] hold,
                            input logic [15:0] tmo);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BIT_HALF;
    cfg_data  <= half;
    @(posedge clk);
    cfg_index <= CFG_EDGE_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= CFG_ACK_TMO;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // data_fix < 0 gives random write bytes
  task automatic run_txn(input bit rd, input logic [7:0] addr, input logic [7:0] idx,
                         input logic [15:0] count, input int p_low, input int noise_pct,
                         input int data_fix);
    item_t w;
    int    d0, need_used;
    d0 = done_seen;
    need_used = need_seen;
    w = rand_word(KIND_START);
    w.is_read     = rd;
    w.device_addr = addr;
    w.reg_index   = idx;
    w.byte_count  = count;
    push_word(w);
    txn_total++;
    if (rd) txn_reads++;
    while (done_seen == d0) begin
      if ($urandom_range(99) < noise_pct) begin
        push_word(noise_word(1'b1));
      end else if (need_seen != need_used) begin
        need_used = need_seen;
        w = rand_word(KIND_DATA);
        if (data_fix >= 0) w.data_byte = 8'(data_fix);
        push_word(w);
      end else begin
        push_word(tick_word(p_low));
      end
    end
  endtask

  task automatic gap_words();
    int n;
    n = $urandom_range(3);
    repeat (n) begin
      if ($urandom_range(4) == 0) push_word(noise_word(1'b0));
      else push_word(tick_word(50));
    end
  endtask

  task automatic random_phase(input int goal);
    int    n, p_low;
    bit    rd;
    logic [15:0] count;
    n = 0;
    while (words_sent < goal) begin
      if (n % 5 == 0)
        set_timing(16'($urandom_range(2)), 16'($urandom_range(3)),
                   TMO_CHOICES[$urandom_range(3)]);
      rd = 1'($urandom);
      case ($urandom_range(2))
        0:       p_low = 100;
        1:       p_low = 90;
        default: p_low = 70;
      endcase
      count = 16'($urandom_range(3));
      if ($urandom_range(9) == 0) begin
        count = 16'($urandom);
        p_low = 0;
      end
      run_txn(rd, 8'($urandom), 8'($urandom), count, p_low, 3, -1);
      gap_words();
      n++;
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_ch.valid = 1'b0;
    {in_ch.kind, in_ch.is_read, in_ch.device_addr, in_ch.reg_index,
     in_ch.byte_count, in_ch.data_byte, in_ch.sda_sample} = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset timing
    run_txn(1'b0, 8'h00, 8'hFF, 16'd1, 100, 0, 255);
    run_txn(1'b1, 8'h7E, 8'h81, 16'd0, 30, 0, -1);
    push_word(rand_word(KIND_NONE));
    push_word(rand_word(KIND_DATA));
    push_word(tick_word(0));

    // zero timing registers, then timeouts on the first high sample
    set_timing(16'd0, 16'd0, 16'd0);
    run_txn(1'b1, 8'hA5, 8'h5A, 16'd3, 100, 0, -1);
    run_txn(1'b0, 8'h3C, 8'h0F, 16'hFFFF, 0, 0, -1);
    run_txn(1'b1, 8'hF0, 8'h55, 16'hFFFF, 0, 0, -1);
    // stray starts and bytes while a transaction runs
    run_txn(1'b0, 8'hC3, 8'h3C, 16'd3, 100, 12, 0);
    run_txn(1'b1, 8'h3C, 8'hC3, 16'd2, 80, 12, -1);

    random_phase(words_sent + RANDOM_WORDS / 3);

    tx_idle_pct = 52;
    rx_idle_pct = 14;
    random_phase(words_sent + RANDOM_WORDS / 3);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // full-scale timing values
    set_timing(16'hFFFF, 16'd1, 16'd1);
    push_word(tick_word(50));
    push_word(rand_word(KIND_NONE));
    set_timing(16'd1, 16'hFFFF, 16'd0);
    push_word(tick_word(50));
    set_timing(16'd1, 16'd1, 16'hFFFF);
    run_txn(1'b1, 8'hE1, 8'h1E, 16'd2, 90, 0, -1);
    random_phase(words_sent + RANDOM_WORDS / 3);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("%0d transactions (%0d reads, %0d aborted for want of an ack), %0d bytes read",
             txn_total, txn_reads, aborts, rx_bytes);
    $display("%0d output words checked, %0d mismatching, %0d still owed",
             words_checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### i2c_register_master_unit.f
src/i2crm_pkg.sv
src/i2crm_in_if.sv
src/i2crm_out_if.sv
src/i2crm_core.sv
src/i2c_register_master_unit.sv
bench/i2crm_checker.sv
bench/tb_top.sv
